### sv/flpw_pkg.sv
`timescale 1ns / 1ps

package flpw_pkg;

  localparam int unsigned VA_W    = 48;
  localparam int unsigned FRAME_W = 36;
  localparam int unsigned ENTRY_W = 64;
  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned LVL_W   = 3;
  localparam int unsigned IDX_W   = 9;
  localparam int unsigned PG_OFS_W = 12;

  localparam logic OP_START = 1'b0;
  localparam logic OP_ENTRY = 1'b1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [LVL_W-1:0] LVL_IDLE = 3'd0;
  localparam logic [LVL_W-1:0] LVL_PML4 = 3'd1;
  localparam logic [LVL_W-1:0] LVL_PDPT = 3'd2;
  localparam logic [LVL_W-1:0] LVL_DIR  = 3'd3;
  localparam logic [LVL_W-1:0] LVL_PTE  = 3'd4;

  localparam int unsigned PRESENT_BIT = 0;
  localparam int unsigned LARGE_BIT   = 7;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_PRESENT = 2'd1,
    ST_READ_FAIL   = 2'd2,
    ST_LARGE_PAGE  = 2'd3
  } status_e;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] read_addr;
    logic [ADDR_W-1:0] phys_addr;
    status_e           status;
    logic [ADDR_W-1:0] leaf_entry_addr;
    logic [LVL_W-1:0]  leaf_level;
  } res_t;

endpackage

### sv/four_level_page_walker.sv
`timescale 1ns / 1ps

// Four-level x86-64 page table walker. A start item (tuser op = 0) carries the
// 48-bit virtual address and the root table frame and yields a read request for
// the top-level entry; each entry item (op = 1) returned by memory yields either
// the next read request or a finished item with status, translated address and
// the deepest entry read. A start while a walk is in flight abandons that walk;
// an entry item while idle produces nothing. The walk state and the result
// register (or, while that is stalled, the skid stage) are updated at the
// accepting edge, so one item per clock is sustained while the skid stage is
// empty, and a two-deep output (result register plus skid stage) keeps the
// input ready while one result waits. Large pages at the PDPT or directory
// level end with status 3. Addresses are held to PA_BITS (capped at 48).
module four_level_page_walker #(
  parameter int unsigned PA_BITS = 48
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // virt_addr[47:0], root_frame[83:48], entry_data[147:84], zero pad
  input  logic [151:0] s_axis_tdata,
  // op[0], read_ok[1]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // read_addr[47:0], phys_addr[95:48], status[97:96],
  // leaf_entry_addr[145:98], leaf_level[148:146], zero pad
  output logic [151:0] m_axis_tdata,
  // kind[0]
  output logic [0:0]   m_axis_tuser
);

  localparam int unsigned AW = (PA_BITS < flpw_pkg::ADDR_W) ? PA_BITS : flpw_pkg::ADDR_W;
  localparam logic [flpw_pkg::ADDR_W-1:0] PA_MASK =
      (AW >= flpw_pkg::ADDR_W) ? {flpw_pkg::ADDR_W{1'b1}}
                               : ((flpw_pkg::ADDR_W'(1) << AW) - flpw_pkg::ADDR_W'(1));
  localparam logic [flpw_pkg::ADDR_W-1:0] FRAME_MASK =
      PA_MASK & ~flpw_pkg::ADDR_W'(12'hFFF);

  logic                              op;
  logic                              read_ok;
  logic [flpw_pkg::VA_W-1:0]         in_vaddr;
  logic [flpw_pkg::FRAME_W-1:0]      in_root;
  logic [flpw_pkg::ENTRY_W-1:0]      in_entry;

  logic [flpw_pkg::LVL_W-1:0]        walk_level_q, walk_level_d;
  logic [flpw_pkg::VA_W-1:0]         saved_vaddr_q, saved_vaddr_d;
  logic [flpw_pkg::ADDR_W-1:0]       pending_q, pending_d;
  logic [flpw_pkg::ADDR_W-1:0]       deepest_q, deepest_d;

  logic                              s_fire;
  logic                              emit;
  flpw_pkg::res_t                    res_d;

  logic                              out_valid_q;
  flpw_pkg::res_t                    out_q;
  logic                              skid_valid_q;
  flpw_pkg::res_t                    skid_q;

  logic [flpw_pkg::LVL_W-1:0]        idx_level;
  logic [flpw_pkg::VA_W-1:0]         idx_vaddr;
  logic [flpw_pkg::ADDR_W-1:0]       idx_base;
  logic [flpw_pkg::IDX_W-1:0]        idx;
  logic [flpw_pkg::ADDR_W-1:0]       next_entry_addr;
  logic [flpw_pkg::ADDR_W-1:0]       entry_frame;
  logic                              entry_present;
  logic                              entry_large;

  assign op       = s_axis_tuser[0];
  assign read_ok  = s_axis_tuser[1];
  assign in_vaddr = s_axis_tdata[47:0];
  assign in_root  = s_axis_tdata[83:48];
  assign in_entry = s_axis_tdata[147:84];

  assign s_axis_tready = !skid_valid_q;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign entry_frame   = in_entry[flpw_pkg::ADDR_W-1:0] & FRAME_MASK;
  assign entry_present = in_entry[flpw_pkg::PRESENT_BIT];
  assign entry_large   = in_entry[flpw_pkg::LARGE_BIT];

  // table base and index for the entry to request next
  always_comb begin
    if (op == flpw_pkg::OP_START) begin
      idx_level = flpw_pkg::LVL_PML4;
      idx_vaddr = in_vaddr;
      idx_base  = {in_root, {flpw_pkg::PG_OFS_W{1'b0}}};
    end else begin
      idx_level = walk_level_q + flpw_pkg::LVL_W'(1);
      idx_vaddr = saved_vaddr_q;
      idx_base  = entry_frame;
    end
  end

  always_comb begin
    unique case (idx_level)
      flpw_pkg::LVL_PML4: idx = idx_vaddr[47:39];
      flpw_pkg::LVL_PDPT: idx = idx_vaddr[38:30];
      flpw_pkg::LVL_DIR:  idx = idx_vaddr[29:21];
      default:            idx = idx_vaddr[20:12];
    endcase
  end

  assign next_entry_addr = (idx_base & FRAME_MASK) | {36'd0, idx, 3'd0};

  always_comb begin
    walk_level_d  = walk_level_q;
    saved_vaddr_d = saved_vaddr_q;
    pending_d     = pending_q;
    deepest_d     = deepest_q;
    emit          = 1'b0;
    res_d         = '0;
    if (op == flpw_pkg::OP_START) begin
      saved_vaddr_d   = in_vaddr;
      deepest_d       = '0;
      pending_d       = next_entry_addr;
      walk_level_d    = flpw_pkg::LVL_PML4;
      emit            = 1'b1;
      res_d.kind      = flpw_pkg::KIND_READ;
      res_d.read_addr = next_entry_addr;
    end else if (walk_level_q != flpw_pkg::LVL_IDLE) begin
      emit       = 1'b1;
      res_d.kind = flpw_pkg::KIND_DONE;
      if (!read_ok) begin
        walk_level_d          = flpw_pkg::LVL_IDLE;
        res_d.status          = flpw_pkg::ST_READ_FAIL;
        res_d.leaf_entry_addr = deepest_q;
        res_d.leaf_level      = walk_level_q - flpw_pkg::LVL_W'(1);
      end else begin
        deepest_d             = pending_q;
        res_d.leaf_entry_addr = pending_q;
        res_d.leaf_level      = walk_level_q;
        walk_level_d          = flpw_pkg::LVL_IDLE;
        if (!entry_present) begin
          res_d.status = flpw_pkg::ST_NOT_PRESENT;
        end else if ((walk_level_q == flpw_pkg::LVL_PDPT ||
                      walk_level_q == flpw_pkg::LVL_DIR) && entry_large) begin
          res_d.status = flpw_pkg::ST_LARGE_PAGE;
        end else if (walk_level_q == flpw_pkg::LVL_PTE) begin
          res_d.status    = flpw_pkg::ST_OK;
          res_d.phys_addr = (entry_frame | {36'd0, saved_vaddr_q[11:0]}) & PA_MASK;
        end else begin
          walk_level_d    = idx_level;
          pending_d       = next_entry_addr;
          res_d.kind      = flpw_pkg::KIND_READ;
          res_d.read_addr = next_entry_addr;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_level_q  <= flpw_pkg::LVL_IDLE;
      saved_vaddr_q <= '0;
      pending_q     <= '0;
      deepest_q     <= '0;
    end else if (s_fire) begin
      walk_level_q  <= walk_level_d;
      saved_vaddr_q <= saved_vaddr_d;
      pending_q     <= pending_d;
      deepest_q     <= deepest_d;
    end
  end

  // result register with skid stage behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q  <= skid_valid_q || (s_fire && emit);
      skid_valid_q <= 1'b0;
    end else if (s_fire && emit) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end else if (s_fire && emit) begin
      skid_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {3'd0, out_q.leaf_level, out_q.leaf_entry_addr, out_q.status,
                          out_q.phys_addr, out_q.read_addr};

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds an item while the result register is empty");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_level_q <= flpw_pkg::LVL_PTE)
    else $error("walk level out of range");

  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && emit && res_d.kind == flpw_pkg::KIND_DONE) |=>
      walk_level_q == flpw_pkg::LVL_IDLE)
    else $error("walk not idle after a finished item");

  a_request_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == flpw_pkg::KIND_READ) |->
      (out_q.status == flpw_pkg::ST_OK && out_q.phys_addr == '0))
    else $error("read request carries completion fields");

endmodule
